// File: sv/spq_pkg.sv
package spq_pkg;

    // Number of cells in the queue and the width of the entry counter.
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int VALUE_W = 32;
    localparam int PRIO_W = 16;

    // Operation codes on the mode port.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Status codes returned with each result word.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  priority_num;
    } entry_t;

    // Operation broadcast to every cell in the same cycle.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t item;
    } cell_op_t;

endpackage

// File: sv/sorted_priority_queue.sv
// Sorted priority queue built as a row of compare-and-shift cells.
// A result word is registered and appears in the cycle after its command is taken.
// Throughput: one command per cycle; busy stays low, since every cell
// compares and shifts in the same cycle. The receiver cannot stall.
// Reset clears the entry count and the result strobe; cell contents are
// meaningless until written and are never read while empty.
module sorted_priority_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic signed [31:0]  item_value,
    input  logic signed [15:0]  item_priority,
    output logic                done,
    output logic signed [31:0]  head_value,
    output logic signed [15:0]  head_priority,
    output logic [1:0]          status,
    output logic [spq_pkg::COUNT_W-1:0] entry_count
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int CW = spq_pkg::COUNT_W;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     done_reg;
    logic signed [31:0]       head_value_reg;
    logic signed [31:0]       head_value_next;
    logic signed [15:0]       head_priority_reg;
    logic signed [15:0]       head_priority_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    spq_pkg::cell_op_t        op;
    spq_pkg::entry_t          entries [DEPTH];
    logic [DEPTH-1:0]         valid;
    logic [DEPTH-1:0]         greater;

    assign busy = 1'b0;
    assign accept = start && !busy;
    assign is_full = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Command decode broadcast to the cells.
    always_comb
    begin
        op.insert = accept && (mode == spq_pkg::MODE_INSERT) && !is_full;
        op.remove = accept && (mode == spq_pkg::MODE_DELETE) && !is_empty;
        op.item.value = item_value;
        op.item.priority_num = item_priority;
    end

    // The row of cells; the occupied cells form a prefix.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign valid[i] = (count_reg > CW'(i));

        if (i == 0)
        begin : g_first
            spq_cell u_cell (
                .clk          (clk),
                .op           (op),
                .own_valid    (valid[i]),
                .prev_valid   (1'b1),
                .prev_greater (1'b0),
                .prev_entry   (entries[i]),
                .next_entry   (entries[i+1]),
                .entry        (entries[i]),
                .greater      (greater[i])
            );
        end
        else if (i == DEPTH - 1)
        begin : g_last
            spq_cell u_cell (
                .clk          (clk),
                .op           (op),
                .own_valid    (valid[i]),
                .prev_valid   (valid[i-1]),
                .prev_greater (greater[i-1]),
                .prev_entry   (entries[i-1]),
                .next_entry   (entries[i]),
                .entry        (entries[i]),
                .greater      (greater[i])
            );
        end
        else
        begin : g_mid
            spq_cell u_cell (
                .clk          (clk),
                .op           (op),
                .own_valid    (valid[i]),
                .prev_valid   (valid[i-1]),
                .prev_greater (greater[i-1]),
                .prev_entry   (entries[i-1]),
                .next_entry   (entries[i+1]),
                .entry        (entries[i]),
                .greater      (greater[i])
            );
        end
    end

    // Next count and result word.
    always_comb
    begin
        count_next = count_reg;
        head_value_next = '0;
        head_priority_next = '0;
        status_next = spq_pkg::ST_OK;
        if (op.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (op.remove)
        begin
            count_next = count_reg - CW'(1);
            head_value_next = entries[0].value;
            head_priority_next = entries[0].priority_num;
        end
        else if (mode == spq_pkg::MODE_INSERT)
        begin
            status_next = spq_pkg::ST_OVERFLOW;
        end
        else
        begin
            status_next = spq_pkg::ST_UNDERFLOW;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_value_reg <= head_value_next;
            head_priority_reg <= head_priority_next;
            status_reg <= status_next;
        end
    end

    assign done = done_reg;
    assign head_value = head_value_reg;
    assign head_priority = head_priority_reg;
    assign status = status_reg;
    assign entry_count = count_reg;

endmodule

// File: sv/spq_cell.sv
module spq_cell (
    input  logic            clk,
    input  spq_pkg::cell_op_t op,
    input  logic            own_valid,
    input  logic            prev_valid,
    input  logic            prev_greater,
    input  spq_pkg::entry_t prev_entry,
    input  spq_pkg::entry_t next_entry,
    output spq_pkg::entry_t entry,
    output logic            greater
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            place_here;

    // This cell holds an entry that must move behind the new one.
    assign greater = own_valid && (entry_reg.priority_num > op.item.priority_num);

    // The new entry lands in the first cell that is greater or the first empty cell.
    assign place_here = !prev_greater && (greater || (!own_valid && prev_valid));

    // Shift right on insert, shift left on delete, otherwise hold.
    always_comb
    begin
        entry_next = entry_reg;
        if (op.insert)
        begin
            if (prev_greater)
            begin
                entry_next = prev_entry;
            end
            else if (place_here)
            begin
                entry_next = op.item;
            end
        end
        else if (op.remove)
        begin
            entry_next = next_entry;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: verif/sorted_priority_queue_test.sv
module sorted_priority_queue_test;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int BURST_LEN = 24;

    // One expected result word, as the block should return it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [PRIO_W-1:0]  prio;
        logic [1:0]                status;
        logic [COUNT_W-1:0]        count;
    } head_word_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        mode = MODE_INSERT;
    logic signed [VALUE_W-1:0]   item_value = '0;
    logic signed [PRIO_W-1:0]    item_priority = '0;
    logic                        busy;
    logic                        done;
    logic signed [VALUE_W-1:0]   head_value;
    logic signed [PRIO_W-1:0]    head_priority;
    logic [1:0]                  status;
    logic [COUNT_W-1:0]          entry_count;

    // Shadow copy of the queue contents, slot 0 is the head.
    logic signed [VALUE_W-1:0]   shadow_value [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]    shadow_prio [QUEUE_DEPTH];
    int                          shadow_count = 0;

    head_word_t                  pending_heads [$];
    int                          mismatch_count = 0;
    int                          cycle_count = 0;
    int                          idle_pct = 0;
    int                          insert_total = 0;
    int                          delete_total = 0;
    int                          underflow_total = 0;
    int                          overflow_total = 0;

    sorted_priority_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .head_value    (head_value),
        .head_priority (head_priority),
        .status        (status),
        .entry_count   (entry_count)
    );

    always #5 clk = ~clk;

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0d] mismatch: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Apply one accepted command to the shadow queue and queue up its result word.
    task automatic predict_head(input logic op, input logic signed [VALUE_W-1:0] v,
                                input logic signed [PRIO_W-1:0] p);
        head_word_t word;
        int pos;
        int i;
        word = '0;
        word.status = ST_OK;
        if (op == MODE_INSERT)
        begin
            insert_total++;
            if (shadow_count >= QUEUE_DEPTH)
            begin
                word.status = ST_OVERFLOW;
                overflow_total++;
            end
            else
            begin
                // The new entry goes behind every entry of lower or equal priority.
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= p)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_value[pos] = v;
                shadow_prio[pos] = p;
                shadow_count++;
            end
        end
        else
        begin
            delete_total++;
            if (shadow_count == 0)
            begin
                word.status = ST_UNDERFLOW;
                underflow_total++;
            end
            else
            begin
                word.value = shadow_value[0];
                word.prio = shadow_prio[0];
                for (i = 0; i + 1 < shadow_count; i++)
                begin
                    shadow_value[i] = shadow_value[i+1];
                    shadow_prio[i] = shadow_prio[i+1];
                end
                shadow_count--;
            end
        end
        word.count = shadow_count[COUNT_W-1:0];
        pending_heads.push_back(word);
    endtask

    // Present one command word and hold it until the block takes it.
    task automatic send_word(input logic op, input logic signed [VALUE_W-1:0] v,
                             input logic signed [PRIO_W-1:0] p);
        start <= 1'b1;
        mode <= op;
        item_value <= v;
        item_priority <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_head(op, v, p);
    endtask

    // Random idle cycles after a word; the data lines carry junk meanwhile.
    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item_value <= $urandom;
            item_priority <= PRIO_W'($urandom);
            @(posedge clk);
        end
    endtask

    // Stop sending until every expected result word has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_heads.size() != 0)
            @(posedge clk);
    endtask

    // Priorities lean toward a narrow band so that ties are common.
    function automatic logic signed [PRIO_W-1:0] rand_prio();
        logic signed [PRIO_W-1:0] p;
        case ($urandom_range(9))
            0: p = 16'sh8000;
            1: p = 16'sh7FFF;
            2, 3, 4, 5: p = $signed(16'($urandom_range(7))) - 16'sd4;
            default: p = PRIO_W'($urandom);
        endcase
        return p;
    endfunction

    // Extreme values and priorities, ties, and deletes on an empty queue.
    task automatic test_directed();
        int k;
        idle_pct = 0;
        send_word(MODE_DELETE, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(MODE_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
        send_word(MODE_INSERT, 32'sh8000_0000, 16'sh8000);
        send_word(MODE_INSERT, 32'sd0, 16'sd0);
        send_word(MODE_INSERT, -32'sd1, -16'sd1);
        send_word(MODE_INSERT, 32'sd5, 16'sd0);
        send_word(MODE_INSERT, 32'sd6, 16'sd0);
        send_word(MODE_INSERT, 32'sd1, 16'sh7FFF);
        send_word(MODE_INSERT, 32'sh5555_AAAA, 16'sh8000);
        for (k = 0; k < 8; k++)
            send_word(MODE_DELETE, $urandom, PRIO_W'($urandom));
        send_word(MODE_DELETE, 32'h0, 16'h0);
        drain_results();
    endtask

    // Fill the queue, push past the top, then empty it and go two further.
    task automatic test_overflow(input int pct);
        int k;
        idle_pct = pct;
        for (k = 0; k < QUEUE_DEPTH + 3; k++)
        begin
            send_word(MODE_INSERT, $urandom, rand_prio());
            idle_gap();
        end
        for (k = 0; k < QUEUE_DEPTH + 2; k++)
        begin
            send_word(MODE_DELETE, $urandom, PRIO_W'($urandom));
            idle_gap();
        end
        drain_results();
    endtask

    // Random traffic in bursts that lean toward filling, emptying or neither.
    task automatic test_random(input int n_words, input int pct);
        int k;
        int insert_pct;
        idle_pct = pct;
        insert_pct = 55;
        for (k = 0; k < n_words; k++)
        begin
            if (k % BURST_LEN == 0)
            begin
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 20;
                    default: insert_pct = 55;
                endcase
            end
            if ($urandom_range(99) < insert_pct)
                send_word(MODE_INSERT, $urandom, rand_prio());
            else
                send_word(MODE_DELETE, $urandom, PRIO_W'($urandom));
            idle_gap();
        end
        drain_results();
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        head_word_t want;
        if (rst_n && done)
        begin
            if (pending_heads.size() == 0)
                report_mismatch("result word with no command pending");
            else
            begin
                want = pending_heads.pop_front();
                check_field("head_value", head_value, want.value);
                check_field("head_priority", head_priority, want.prio);
                check_field("status", status, want.status);
                check_field("entry_count", entry_count, want.count);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overflow(0);
        test_random(230, 0);
        test_random(230, 68);
        test_overflow(29);
        test_random(230, 0);
        test_random(230, 29);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d inserts and %0d deletes in %0d cycles",
                 insert_total, delete_total, cycle_count);
        $display("with %0d overflow drops and %0d empty deletes, %0d mismatches",
                 overflow_total, underflow_total, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
verif/sorted_priority_queue_test.sv
